// File: hw/rtl/u16u8_pkg.sv
package u16u8_pkg;

	// result status codes, carried in m_tuser
	localparam logic [1:0] ST_OK            = 2'd0;
	localparam logic [1:0] ST_UNPAIRED_HIGH = 2'd1;
	localparam logic [1:0] ST_LONE_LOW      = 2'd2;

	localparam int unsigned MAX_RES = 4;
	localparam int unsigned RES_IW  = $clog2(MAX_RES);

	// surrogate tags, unit bits 15..10
	localparam logic [5:0] TAG_HIGH = 6'b110110;
	localparam logic [5:0] TAG_LOW  = 6'b110111;

	localparam logic [20:0] SUPP_BASE = 21'h10000;

	// all results caused by one input unit, first result in entry 0
	typedef struct packed {
		logic [MAX_RES-1:0][7:0]  data;
		logic [MAX_RES-1:0][1:0]  status;
		logic [RES_IW-1:0]        last_idx;
	} job_t;

	// queue status towards the top level
	typedef struct packed {
		logic                     full;
		logic                     empty;
		logic [4:0]               count;
	} q_stat_t;

	typedef struct packed {
		logic [MAX_RES-1:0][7:0]  data;
		logic [2:0]               n;
	} enc_t;

	function automatic enc_t utf8_encode(input logic [20:0] cp);
		enc_t e;
		e = '0;
		if (cp <= 21'h7F) begin
			e.data[0] = cp[7:0];
			e.n       = 3'd1;
		end else if (cp <= 21'h7FF) begin
			e.data[0] = {3'b110, cp[10:6]};
			e.data[1] = {2'b10, cp[5:0]};
			e.n       = 3'd2;
		end else if (cp <= 21'hFFFF) begin
			e.data[0] = {4'b1110, cp[15:12]};
			e.data[1] = {2'b10, cp[11:6]};
			e.data[2] = {2'b10, cp[5:0]};
			e.n       = 3'd3;
		end else begin
			e.data[0] = {5'b11110, cp[20:18]};
			e.data[1] = {2'b10, cp[17:12]};
			e.data[2] = {2'b10, cp[11:6]};
			e.data[3] = {2'b10, cp[5:0]};
			e.n       = 3'd4;
		end
		return e;
	endfunction

endpackage

// File: hw/rtl/u16u8_front.sv
module u16u8_front
	import u16u8_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [15:0] code_unit,
	input  logic        string_end,
	output logic        push,
	output job_t        job
);

	logic [9:0] held_bits_q;
	logic       held_q;

	logic        is_high, is_low, pair, prefix;
	logic [20:0] cp;
	enc_t        enc;
	logic [MAX_RES-1:0][7:0] cur_d;
	logic [MAX_RES-1:0][1:0] cur_s;
	logic [2:0]  cur_n;
	logic [2:0]  total_n;

	assign is_high = code_unit[15:10] == TAG_HIGH;
	assign is_low  = code_unit[15:10] == TAG_LOW;
	assign pair    = held_q && is_low;
	assign prefix  = held_q && !is_low;

	always_comb begin
		if (pair) begin
			cp = SUPP_BASE + {1'b0, held_bits_q, code_unit[9:0]};
		end else begin
			cp = {5'd0, code_unit};
		end
	end

	assign enc = utf8_encode(cp);

	// results of the current unit alone
	always_comb begin
		cur_d = enc.data;
		cur_s = '0;
		cur_n = enc.n;
		if (!pair && is_high) begin
			cur_d    = '0;
			cur_s[0] = ST_UNPAIRED_HIGH;
			cur_n    = string_end ? 3'd1 : 3'd0;
		end else if (!pair && is_low) begin
			cur_d    = '0;
			cur_s[0] = ST_LONE_LOW;
			cur_n    = 3'd1;
		end
	end

	// a dropped hold goes first, then the unit's own results
	always_comb begin
		job.data   = cur_d;
		job.status = cur_s;
		if (prefix) begin
			job.data[0]   = 8'd0;
			job.status[0] = ST_UNPAIRED_HIGH;
			for (int i = 1; i < MAX_RES; i++) begin
				job.data[i]   = cur_d[i-1];
				job.status[i] = cur_s[i-1];
			end
		end
		total_n      = cur_n + {2'd0, prefix};
		job.last_idx = RES_IW'(total_n - 3'd1);
	end

	assign push = accept && (total_n != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= 1'b0;
			held_bits_q <= '0;
		end else if (accept) begin
			held_q      <= !pair && is_high && !string_end;
			held_bits_q <= (!pair && is_high && !string_end) ? code_unit[9:0] : 10'd0;
		end
	end

endmodule

// File: hw/rtl/u16u8_queue.sv
module u16u8_queue
	import u16u8_pkg::*;
#(
	parameter int unsigned DEPTH = 2
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  job_t    push_job,
	input  logic    pop,
	output job_t    pop_job,
	output q_stat_t stat
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= bump(wr_ptr_q);
			if (pop)  rd_ptr_q <= bump(rd_ptr_q);
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

	assign stat.full  = count_q == CW'(DEPTH);
	assign stat.empty = count_q == '0;
	assign stat.count = 5'(count_q);

endmodule

// File: hw/rtl/u16u8_back.sv
module u16u8_back
	import u16u8_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       job_avail,
	input  job_t       job_in,
	output logic       job_take,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [1:0] out_status,
	output logic       out_last
);

	job_t              cur_q;
	logic              valid_q;
	logic [RES_IW-1:0] idx_q;

	logic fire;

	assign out_valid  = valid_q;
	assign out_byte   = cur_q.data[idx_q];
	assign out_status = cur_q.status[idx_q];
	assign out_last   = idx_q == cur_q.last_idx;
	assign fire       = valid_q && out_ready;

	assign job_take = job_avail && (!valid_q || (fire && out_last));

	always_ff @(posedge clk) begin
		if (job_take) cur_q <= job_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (job_take) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (fire) begin
			if (out_last) begin
				valid_q <= 1'b0;
				idx_q   <= '0;
			end else begin
				idx_q <= idx_q + RES_IW'(1);
			end
		end
	end

endmodule

// File: hw/rtl/utf16_to_utf8_transcoder_top.sv
// channel  dir  tdata                 tuser        tlast
// s_*      in   [15:0] code_unit      -            string_end
// m_*      out  [7:0]  utf8_byte      [1:0] status run_last
//
// One result transaction per cycle leaves the output while m_tready is high: a unit yields 0 to 4
// results there, walked by the back end (a BMP unit up to 3, one more after a dropped hold).
// Input is taken every cycle while the job queue (QUEUE_DEPTH jobs) has room.
// A held high surrogate yields no output transaction; in an idle block the input transaction
// is registered in the queue, then in the back end's job register, before m_tvalid rises.
// Asynchronous active-low reset empties the queue and drops any held surrogate.
// Output stalls fill the queue, then s_tready falls; the front never stalls the back.
module utf16_to_utf8_transcoder_top
	import u16u8_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] code_unit
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] utf8_byte
	output logic [1:0]  m_tuser,   // [1:0] status
	output logic        m_tlast
);

	logic    accept, push, take;
	job_t    push_job, head_job;
	q_stat_t q_stat;

	assign s_tready = !q_stat.full;
	assign accept   = s_tvalid && s_tready;

	// front: surrogate pairing and byte expansion into at most one job per unit
	u16u8_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.code_unit  (s_tdata),
		.string_end (s_tlast),
		.push       (push),
		.job        (push_job)
	);

	// job queue, decouples the unit rate from the byte rate
	u16u8_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (take),
		.pop_job  (head_job),
		.stat     (q_stat)
	);

	// back: walks the job's results, one transaction per cycle while m_tready is high
	u16u8_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_avail  (!q_stat.empty),
		.job_in     (head_job),
		.job_take   (take),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_byte   (m_tdata),
		.out_status (m_tuser),
		.out_last   (m_tlast)
	);

`ifndef SYNTHESIS
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= 5'(QUEUE_DEPTH))
		else $error("job queue overfilled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_OK) |-> (m_tdata == 8'd0))
		else $error("error result carries a non-zero byte");

	a_lone_low_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_LONE_LOW) |-> m_tlast)
		else $error("lone low surrogate error not last of its run");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(push && q_stat.empty && !m_tvalid) |-> ##2 m_tvalid)
		else $error("job pushed into idle block not shown in time");
`endif

endmodule

// File: test/tb_utf16_to_utf8_transcoder_top.sv
module tb_utf16_to_utf8_transcoder_top
	import u16u8_pkg::*;
();

	// cycles with no transaction on either side before the run is abandoned
	localparam int unsigned STALL_LIMIT = 2000;
	// settle time after the last expected byte
	localparam int unsigned DRAIN_TAIL  = 16;
	localparam int unsigned IDLE_PCT    = 13;

	// one output transaction as the checker sees it
	typedef struct packed {
		logic [7:0] utf8_byte;
		logic [1:0] status;
		logic       run_last;
	} utf8_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // [15:0] code_unit
	logic        s_tlast = 1'b0; // string_end
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // [7:0] utf8_byte
	logic [1:0]  m_tuser;        // [1:0] status
	logic        m_tlast;        // run_last

	// set during the back-to-back stretch: neither side idles
	logic        no_idle = 1'b0;
	logic        failed = 1'b0;
	int unsigned quiet_cycles = 0;

	// predictor state: the pending high surrogate
	logic [9:0]  held_bits = '0;
	logic        held_valid = 1'b0;

	// bytes and errors still owed by the block, oldest first
	utf8_result_t utf8_expected[$];

	// scratch for the results of one unit
	utf8_result_t unit_res [4];
	int           unit_cnt;

	utf16_to_utf8_transcoder_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------
	function automatic void add_result(input logic [7:0] b, input logic [1:0] st);
		unit_res[unit_cnt] = '{utf8_byte: b, status: st, run_last: 1'b0};
		unit_cnt++;
	endfunction

	// split a scalar value into its UTF-8 byte sequence
	function automatic void add_code_point(input logic [20:0] cp);
		if (cp < 21'h80) begin
			add_result(cp[7:0], ST_OK);
		end else if (cp < 21'h800) begin
			add_result({3'b110, cp[10:6]}, ST_OK);
			add_result({2'b10, cp[5:0]}, ST_OK);
		end else if (cp < 21'h10000) begin
			add_result({4'b1110, cp[15:12]}, ST_OK);
			add_result({2'b10, cp[11:6]}, ST_OK);
			add_result({2'b10, cp[5:0]}, ST_OK);
		end else begin
			add_result({5'b11110, cp[20:18]}, ST_OK);
			add_result({2'b10, cp[17:12]}, ST_OK);
			add_result({2'b10, cp[11:6]}, ST_OK);
			add_result({2'b10, cp[5:0]}, ST_OK);
		end
	endfunction

	// work out everything one accepted unit should produce, queue it up
	function automatic void predict_unit(input logic [15:0] unit, input logic str_end);
		logic is_high;
		logic is_low;
		is_high  = (unit[15:10] == TAG_HIGH);
		is_low   = (unit[15:10] == TAG_LOW);
		unit_cnt = 0;
		if (held_valid && is_low) begin
			add_code_point(SUPP_BASE + {1'b0, held_bits, unit[9:0]});
			held_valid = 1'b0;
		end else begin
			// held high not followed by a low: flag it, then treat this unit afresh
			if (held_valid) begin
				add_result(8'h00, ST_UNPAIRED_HIGH);
				held_valid = 1'b0;
			end
			if (is_high) begin
				if (str_end)
					add_result(8'h00, ST_UNPAIRED_HIGH);
				else begin
					held_bits  = unit[9:0];
					held_valid = 1'b1;
				end
			end else if (is_low) begin
				add_result(8'h00, ST_LONE_LOW);
			end else begin
				add_code_point({5'd0, unit});
			end
		end
		// nothing survives a string boundary
		if (str_end)
			held_valid = 1'b0;
		if (unit_cnt > 0)
			unit_res[unit_cnt-1].run_last = 1'b1;
		for (int i = 0; i < unit_cnt; i++)
			utf8_expected.push_back(unit_res[i]);
	endfunction

	// ---------------------------------------------------------------
	// input side
	// ---------------------------------------------------------------
	// one input transaction; returns at the edge where it is taken
	task automatic send_unit(input logic [15:0] unit, input logic str_end);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		predict_unit(unit, str_end);
		s_tvalid <= 1'b1;
		s_tdata  <= unit;
		s_tlast  <= str_end;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// hold the input off until every owed result has left the block
	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		while (utf8_expected.size() != 0)
			@(posedge clk);
	endtask

	// one code point drawn from a mix weighted towards well-formed text;
	// a supplementary one comes back as two units
	task automatic pick_code_point(output logic [15:0] u0, output logic [15:0] u1,
			output int n_units);
		int unsigned kind;
		int unsigned v;
		kind    = $urandom_range(99);
		n_units = 1;
		u1      = '0;
		if (kind < 25) begin
			u0 = 16'($urandom_range(16'h007F));
		end else if (kind < 45) begin
			u0 = 16'($urandom_range(16'h07FF, 16'h0080));
		end else if (kind < 65) begin
			v = $urandom_range(16'hF7FF, 16'h0800);
			// step over the surrogate block
			if (v >= 16'hD800)
				v += 16'h0800;
			u0 = 16'(v);
		end else if (kind < 85) begin
			v       = $urandom_range(20'hFFFFF);
			u0      = {TAG_HIGH, 10'(v >> 10)};
			u1      = {TAG_LOW, 10'(v)};
			n_units = 2;
		end else if (kind < 90) begin
			u0 = {TAG_HIGH, 10'($urandom_range(10'h3FF))};
		end else if (kind < 95) begin
			u0 = {TAG_LOW, 10'($urandom_range(10'h3FF))};
		end else begin
			u0 = 16'($urandom_range(16'hFFFF));
		end
	endtask

	// whole strings of 1..8 code points until at least n_min units went in
	task automatic send_random_strings(input int n_min);
		logic [15:0] str[$];
		logic [15:0] u0;
		logic [15:0] u1;
		int          n_units;
		int          len;
		int          sent;
		sent = 0;
		while (sent < n_min) begin
			str.delete();
			len = $urandom_range(8, 1);
			repeat (len) begin
				pick_code_point(u0, u1, n_units);
				str.push_back(u0);
				if (n_units == 2)
					str.push_back(u1);
			end
			foreach (str[i])
				send_unit(str[i], i == str.size() - 1);
			sent += str.size();
		end
	endtask

	// ---------------------------------------------------------------
	// test cases
	// ---------------------------------------------------------------
	task automatic test_directed_cases();
		// range boundaries of each byte length
		send_unit(16'h0000, 1'b0);
		send_unit(16'h007F, 1'b0);
		send_unit(16'h0080, 1'b0);
		send_unit(16'h07FF, 1'b0);
		send_unit(16'h0800, 1'b0);
		send_unit(16'hFFFF, 1'b1);
		send_unit(16'hD7FF, 1'b0);
		send_unit(16'hE000, 1'b1);
		// lowest and highest supplementary, the latter closing the string
		send_unit(16'hD800, 1'b0);
		send_unit(16'hDC00, 1'b0);
		send_unit(16'hDBFF, 1'b0);
		send_unit(16'hDFFF, 1'b1);
		// high surrogate as the final unit
		send_unit(16'hDBFF, 1'b1);
		// held high broken by ASCII: error then the byte
		send_unit(16'hD800, 1'b0);
		send_unit(16'h0041, 1'b0);
		// held high replaced by another high, which then pairs
		send_unit(16'hDABC, 1'b0);
		send_unit(16'hD9AA, 1'b0);
		send_unit(16'hDD55, 1'b0);
		// lone lows, mid-string and at the end
		send_unit(16'hDC00, 1'b0);
		send_unit(16'hDFFF, 1'b1);
		// held high broken by a 3-byte unit
		send_unit(16'hD801, 1'b0);
		send_unit(16'h20AC, 1'b0);
		// held high then a high at string end: two errors
		send_unit(16'hDB00, 1'b0);
		send_unit(16'hDBFF, 1'b1);
		// held high broken by a 2-byte unit that ends the string
		send_unit(16'hD834, 1'b0);
		send_unit(16'h07FF, 1'b1);
	endtask

	// full rate on both sides for a long stretch
	task automatic test_back_to_back();
		no_idle = 1'b1;
		send_random_strings(80);
		no_idle = 1'b0;
	endtask

	// let the pipeline empty completely between bursts
	task automatic test_drain_pause();
		repeat (4) begin
			send_random_strings(10);
			wait_for_drain();
		end
	endtask

	// ---------------------------------------------------------------
	// output side
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (no_idle)
			m_tready <= 1'b1;
		else
			m_tready <= ($urandom_range(99) >= IDLE_PCT);
	end

	// every output transaction against the oldest owed result
	always @(posedge clk) begin
		utf8_result_t exp_res;
		if (arst_n && m_tvalid && m_tready) begin
			if (utf8_expected.size() == 0) begin
				$error("unexpected result: utf8_byte %02h status %0d run_last %0b",
					m_tdata, m_tuser, m_tlast);
				failed = 1'b1;
			end else begin
				exp_res = utf8_expected.pop_front();
				if (m_tdata !== exp_res.utf8_byte) begin
					$error("utf8_byte: expected %02h, got %02h", exp_res.utf8_byte, m_tdata);
					failed = 1'b1;
				end
				if (m_tuser !== exp_res.status) begin
					$error("status: expected %0d, got %0d", exp_res.status, m_tuser);
					failed = 1'b1;
				end
				if (m_tlast !== exp_res.run_last) begin
					$error("run_last: expected %0b, got %0b", exp_res.run_last, m_tlast);
					failed = 1'b1;
				end
			end
		end
	end

	// watchdog: give up once nothing has moved on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb_utf16_to_utf8_transcoder_top: FAIL");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// sequence
	// ---------------------------------------------------------------
	initial begin
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		send_random_strings(120);
		test_back_to_back();
		test_drain_pause();
		send_random_strings(40);

		wait_for_drain();
		repeat (DRAIN_TAIL)
			@(posedge clk);
		if (utf8_expected.size() != 0) begin
			$error("%0d expected results never arrived", utf8_expected.size());
			failed = 1'b1;
		end
		if (!failed)
			$display("tb_utf16_to_utf8_transcoder_top: PASS");
		else
			$display("tb_utf16_to_utf8_transcoder_top: FAIL");
		$finish;
	end

endmodule
